>>> hw/rtl/tssr_pkg.sv
// ---------------------------------------------------------------------------
// tssr_pkg
// shared codes, controller states, command/status types and shade helpers
// ---------------------------------------------------------------------------
`default_nettype none
package tssr_pkg;

	// request kinds
	localparam logic [1:0] ACT_VRAM_WR = 2'd0;
	localparam logic [1:0] ACT_SPR_WR  = 2'd1;
	localparam logic [1:0] ACT_RENDER  = 2'd2;
	localparam logic [1:0] ACT_WIN_CLR = 2'd3;

	// configuration register indexes
	localparam logic [2:0] REG_LCDC = 3'd0;
	localparam logic [2:0] REG_SCY  = 3'd1;
	localparam logic [2:0] REG_SCX  = 3'd2;
	localparam logic [2:0] REG_WY   = 3'd3;
	localparam logic [2:0] REG_WX   = 3'd4;
	localparam logic [2:0] REG_BGP  = 3'd5;
	localparam logic [2:0] REG_OBP0 = 3'd6;
	localparam logic [2:0] REG_OBP1 = 3'd7;

	// lcd control bit positions
	localparam int LC_DISP = 7;
	localparam int LC_WMAP = 6;
	localparam int LC_WIN  = 5;
	localparam int LC_TSET = 4;
	localparam int LC_BMAP = 3;
	localparam int LC_TALL = 2;
	localparam int LC_SPR  = 1;
	localparam int LC_BG   = 0;

	localparam logic [12:0] MAP_LO = 13'h1800;
	localparam logic [12:0] MAP_HI = 13'h1C00;
	localparam logic [7:0]  WIN_TOP_MAX = 8'd143;

	// controller states
	localparam logic [4:0] ST_IDLE    = 5'd0;
	localparam logic [4:0] ST_PX_MAP  = 5'd1;
	localparam logic [4:0] ST_PX_LO   = 5'd2;
	localparam logic [4:0] ST_PX_HI   = 5'd3;
	localparam logic [4:0] ST_PX_WR   = 5'd4;
	localparam logic [4:0] ST_SP_A0   = 5'd5;
	localparam logic [4:0] ST_SP_A1   = 5'd6;
	localparam logic [4:0] ST_SP_A2   = 5'd7;
	localparam logic [4:0] ST_SP_A3   = 5'd8;
	localparam logic [4:0] ST_SP_CHK  = 5'd9;
	localparam logic [4:0] ST_SP_HI   = 5'd10;
	localparam logic [4:0] ST_SP_LOAD = 5'd11;
	localparam logic [4:0] ST_SP_PRD  = 5'd12;
	localparam logic [4:0] ST_SP_PWR  = 5'd13;
	localparam logic [4:0] ST_OUT_RD  = 5'd14;
	localparam logic [4:0] ST_OUT_CAP = 5'd15;
	localparam logic [4:0] ST_OUT_SND = 5'd16;

	typedef struct packed {
		logic       accept;
		logic       next_grp;
		logic [4:0] state;
	} cmd_t;

	typedef struct packed {
		logic disp_on;
		logic spr_on;
		logic fetch;
		logic pix_last;
		logic hit;
		logic spr_last;
		logic k_last;
		logic j_last;
		logic grp_last;
	} stat_t;

	function automatic logic [7:0] grey_of(input logic [1:0] shade);
		logic [7:0] g;
		case (shade)
			2'd0: g = 8'hFF;
			2'd1: g = 8'hC0;
			2'd2: g = 8'h60;
			default: g = 8'h00;
		endcase
		return g;
	endfunction

	function automatic logic [1:0] pal_shade(input logic [7:0] pal, input logic [1:0] colour);
		logic [7:0] sh;
		sh = pal >> {colour, 1'b0};
		return sh[1:0];
	endfunction

endpackage
`default_nettype wire

>>> hw/rtl/tssr_ctrl.sv
// ---------------------------------------------------------------------------
// tssr_ctrl
// sequencer: background/window pass, sprite pass, group output
// ---------------------------------------------------------------------------
`default_nettype none
module tssr_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	input  wire logic [1:0]      in_action,
	input  wire logic            out_ready,
	input  wire tssr_pkg::stat_t stat,
	output tssr_pkg::cmd_t       cmd,
	output logic                 in_ready
);
	import tssr_pkg::*;

	logic [4:0] state_q;
	logic [4:0] state_d;
	logic       accept;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;

	assign cmd.accept   = accept;
	assign cmd.next_grp = (state_q == ST_OUT_SND) && out_ready;
	assign cmd.state    = state_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && in_action == ACT_RENDER)
					state_d = stat.disp_on ? ST_PX_MAP : ST_OUT_RD;
			end
			ST_PX_MAP:  state_d = stat.fetch ? ST_PX_LO : ST_PX_WR;
			ST_PX_LO:   state_d = ST_PX_HI;
			ST_PX_HI:   state_d = ST_PX_WR;
			ST_PX_WR: begin
				if (stat.pix_last)
					state_d = stat.spr_on ? ST_SP_A0 : ST_OUT_RD;
				else
					state_d = ST_PX_MAP;
			end
			ST_SP_A0:   state_d = ST_SP_A1;
			ST_SP_A1:   state_d = ST_SP_A2;
			ST_SP_A2:   state_d = ST_SP_A3;
			ST_SP_A3:   state_d = ST_SP_CHK;
			ST_SP_CHK: begin
				if (stat.hit)
					state_d = ST_SP_HI;
				else
					state_d = stat.spr_last ? ST_OUT_RD : ST_SP_A0;
			end
			ST_SP_HI:   state_d = ST_SP_LOAD;
			ST_SP_LOAD: state_d = ST_SP_PRD;
			ST_SP_PRD:  state_d = ST_SP_PWR;
			ST_SP_PWR: begin
				if (stat.k_last)
					state_d = stat.spr_last ? ST_OUT_RD : ST_SP_A0;
				else
					state_d = ST_SP_PRD;
			end
			ST_OUT_RD:  state_d = ST_OUT_CAP;
			ST_OUT_CAP: state_d = stat.j_last ? ST_OUT_SND : ST_OUT_RD;
			ST_OUT_SND: begin
				if (out_ready)
					state_d = stat.grp_last ? ST_IDLE : ST_OUT_RD;
			end
			default:    state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	a_off_goes_out: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && in_action == ACT_RENDER && !stat.disp_on) |=> state_q == ST_OUT_RD)
		else $error("display-off render did not go to output");

	a_send_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT_SND && !out_ready) |=> state_q == ST_OUT_SND)
		else $error("group left before it was taken");

	a_write_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && in_action != ACT_RENDER) |=> state_q == ST_IDLE)
		else $error("non-render request left idle");

endmodule
`default_nettype wire

>>> hw/rtl/tssr_dp.sv
// ---------------------------------------------------------------------------
// tssr_dp
// video memory, sprite table, line buffer, config registers and pixel logic
// ---------------------------------------------------------------------------
`default_nettype none
module tssr_dp #(
	parameter int SCREEN_WIDTH = 160,
	parameter int SPRITE_COUNT = 40,
	parameter int TILE_COUNT   = 384
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            cfg_we,
	input  wire logic [2:0]      cfg_index,
	input  wire logic [7:0]      cfg_data,
	input  wire logic [1:0]      in_action,
	input  wire logic [12:0]     in_addr,
	input  wire logic [7:0]      in_data,
	input  wire logic [7:0]      in_line,
	input  wire tssr_pkg::cmd_t  cmd,
	output tssr_pkg::stat_t      stat,
	output logic                 out_valid,
	output logic [5:0]           out_group,
	output logic [31:0]          out_pixels,
	output logic                 out_last
);
	import tssr_pkg::*;

	localparam int PIX_W     = $clog2(SCREEN_WIDTH);
	localparam int SPR_BYTES = SPRITE_COUNT * 4;
	localparam int SA_W      = $clog2(SPR_BYTES);
	localparam int SC_W      = (SPRITE_COUNT > 1) ? $clog2(SPRITE_COUNT) : 1;
	localparam int GROUPS    = (SCREEN_WIDTH + 3) / 4;
	localparam int GR_W      = $clog2(GROUPS);
	localparam int OP_W      = GR_W + 2;

	// configuration registers
	logic [7:0] lcdc_q, scy_q, scx_q, wy_top_q, wx_q, bgp_q, obp0_q, obp1_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lcdc_q   <= 8'd0;
			scy_q    <= 8'd0;
			scx_q    <= 8'd0;
			wy_top_q <= 8'd0;
			wx_q     <= 8'd0;
			bgp_q    <= 8'd228;
			obp0_q   <= 8'd228;
			obp1_q   <= 8'd228;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_LCDC: lcdc_q   <= cfg_data;
				REG_SCY:  scy_q    <= cfg_data;
				REG_SCX:  scx_q    <= cfg_data;
				REG_WY:   wy_top_q <= cfg_data;
				REG_WX:   wx_q     <= cfg_data;
				REG_BGP:  bgp_q    <= cfg_data;
				REG_OBP0: obp0_q   <= cfg_data;
				REG_OBP1: obp1_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// memories
	logic [7:0]  vram [0:8191];
	logic [7:0]  vram_rd_q;
	logic [12:0] vram_ra;
	logic        vram_we;

	logic [7:0]        oam [0:SPR_BYTES-1];
	logic [7:0]        oam_rd_q;
	logic              oam_we;
	logic [SC_W+1:0]   oam_ra_full;
	logic [1:0]        oam_byte;

	logic [3:0]        lbuf [0:SCREEN_WIDTH-1];
	logic [3:0]        lb_rd_q;
	logic [PIX_W-1:0]  lb_ra;
	logic [PIX_W-1:0]  lb_wa;
	logic [3:0]        lb_wd;
	logic              lb_we;

	// per-line and per-item registers
	logic [7:0]       line_q, sy_q, wy_q, win_cnt_q;
	logic             win_line_q;
	logic [PIX_W-1:0] pix_q;
	logic [SC_W-1:0]  s_q;
	logic [2:0]       k_q;
	logic [GR_W-1:0]  g_q;
	logic [1:0]       j_q;
	logic [2:0]       col_q, row_q;
	logic             tok_q;
	logic [12:0]      addr_q;
	logic [7:0]       lo_q, hi_q;
	logic [7:0]       oy_q, ox_q, ot_q, attr_q;
	logic [PIX_W-1:0] p_q;
	logic             pin_q;
	logic [31:0]      word_q;

	logic accept_wr, accept_spr, accept_rnd, accept_clr;
	assign accept_wr  = cmd.accept && in_action == ACT_VRAM_WR;
	assign accept_spr = cmd.accept && in_action == ACT_SPR_WR;
	assign accept_rnd = cmd.accept && in_action == ACT_RENDER;
	assign accept_clr = cmd.accept && in_action == ACT_WIN_CLR;

	logic win_line;
	assign win_line = lcdc_q[LC_WIN] && (in_line >= wy_top_q) && (wy_top_q <= WIN_TOP_MAX)
		&& ({2'b00, wx_q} <= 10'(SCREEN_WIDTH + 6));

	// background / window pixel address
	logic        win_px;
	logic [9:0]  wc;
	logic [7:0]  sx;
	logic [12:0] map_addr;
	logic [8:0]  bg_idx;
	logic [12:0] tile_addr;
	logic [2:0]  bit_px;
	logic [1:0]  px_colour;

	assign win_px   = win_line_q && ((10'(pix_q) + 10'd7) >= {2'b00, wx_q});
	assign wc       = 10'(pix_q) + 10'd7 - {2'b00, wx_q};
	assign sx       = scx_q + 8'(pix_q);
	assign map_addr = win_px
		? ((lcdc_q[LC_WMAP] ? MAP_HI : MAP_LO) | {3'b000, wy_q[7:3], wc[7:3]})
		: ((lcdc_q[LC_BMAP] ? MAP_HI : MAP_LO) | {3'b000, sy_q[7:3], sx[7:3]});
	// signed tile set: indexes below 128 sit in the upper block
	assign bg_idx    = {~lcdc_q[LC_TSET] & ~vram_rd_q[7], vram_rd_q};
	assign tile_addr = {bg_idx, row_q, 1'b0};
	assign bit_px    = ~col_q;
	assign px_colour = tok_q ? {vram_rd_q[bit_px], lo_q[bit_px]} : 2'd0;

	// sprite row test
	logic [9:0]  l16, dy;
	logic        hit, lower;
	logic [7:0]  tile_adj;
	logic [2:0]  spr_row;
	logic [7:0]  attr;
	logic [12:0] spr_addr;

	assign attr     = oam_rd_q;
	assign l16      = {2'b00, line_q} + 10'd16;
	assign dy       = l16 - {2'b00, oy_q};
	assign hit      = (l16 >= {2'b00, oy_q}) && (dy < (lcdc_q[LC_TALL] ? 10'd16 : 10'd8));
	assign lower    = attr[6] ? ~dy[3] : dy[3];
	assign tile_adj = lcdc_q[LC_TALL] ? (lower ? (ot_q | 8'h01) : (ot_q & 8'hFE)) : ot_q;
	assign spr_row  = attr[6] ? ~dy[2:0] : dy[2:0];
	assign spr_addr = {1'b0, tile_adj, spr_row, 1'b0};

	// sprite pixel
	logic [9:0] xk, pv;
	logic       pin;
	logic [2:0] sbit;
	logic [1:0] s_colour;
	logic [7:0] s_pal;

	assign xk       = {2'b00, ox_q} + 10'(k_q);
	assign pv       = xk - 10'd8;
	assign pin      = (xk >= 10'd8) && (xk < 10'(SCREEN_WIDTH + 8));
	assign sbit     = attr_q[5] ? k_q : ~k_q;
	assign s_colour = {hi_q[sbit], lo_q[sbit]};
	assign s_pal    = attr_q[4] ? obp1_q : obp0_q;

	// output
	logic [OP_W-1:0] opix;
	logic [7:0]      grey;
	assign opix = {g_q, j_q};
	assign grey = (lcdc_q[LC_DISP] && ({1'b0, 8'(opix)} < 9'(SCREEN_WIDTH)))
		? grey_of(lb_rd_q[1:0]) : 8'hFF;

	always_comb begin
		vram_we = accept_wr;
		vram_ra = map_addr;
		oam_byte = 2'd0;
		lb_ra   = pix_q;
		lb_we   = 1'b0;
		lb_wa   = pix_q;
		lb_wd   = {px_colour, pal_shade(bgp_q, px_colour)};
		case (cmd.state)
			ST_PX_LO:  vram_ra = tile_addr;
			ST_PX_HI:  vram_ra = {addr_q[12:1], 1'b1};
			ST_PX_WR:  lb_we = 1'b1;
			ST_SP_A1:  oam_byte = 2'd1;
			ST_SP_A2:  oam_byte = 2'd2;
			ST_SP_A3:  oam_byte = 2'd3;
			ST_SP_CHK: vram_ra = spr_addr;
			ST_SP_HI:  vram_ra = {addr_q[12:1], 1'b1};
			ST_SP_PRD: lb_ra = pv[PIX_W-1:0];
			ST_SP_PWR: begin
				lb_wa = p_q;
				lb_wd = {lb_rd_q[3:2], pal_shade(s_pal, s_colour)};
				lb_we = pin_q && s_colour != 2'd0 && (!attr_q[7] || lb_rd_q[3:2] == 2'd0);
			end
			ST_OUT_RD: lb_ra = opix[PIX_W-1:0];
			default: ;
		endcase
	end

	assign oam_ra_full = {s_q, oam_byte};
	assign oam_we      = accept_spr && (in_addr < 13'(SPR_BYTES));

	always_ff @(posedge clk) begin
		if (vram_we)
			vram[in_addr] <= in_data;
		else
			vram_rd_q <= vram[vram_ra];
	end

	always_ff @(posedge clk) begin
		if (oam_we)
			oam[in_addr[SA_W-1:0]] <= in_data;
		oam_rd_q <= oam[oam_ra_full[SA_W-1:0]];
	end

	always_ff @(posedge clk) begin
		if (lb_we)
			lbuf[lb_wa] <= lb_wd;
		lb_rd_q <= lbuf[lb_ra];
	end

	// window line counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			win_cnt_q <= 8'd0;
		else if (accept_clr)
			win_cnt_q <= 8'd0;
		else if (accept_rnd && lcdc_q[LC_DISP] && win_line)
			win_cnt_q <= win_cnt_q + 8'd1;
	end

	// counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_q <= '0;
			s_q   <= '0;
			k_q   <= '0;
			g_q   <= '0;
			j_q   <= '0;
		end else if (accept_rnd) begin
			pix_q <= '0;
			s_q   <= '0;
			k_q   <= '0;
			g_q   <= '0;
			j_q   <= '0;
		end else begin
			case (cmd.state)
				ST_PX_WR:   pix_q <= pix_q + 1'b1;
				ST_SP_CHK:  if (!hit) s_q <= s_q + 1'b1;
				ST_SP_LOAD: k_q <= '0;
				ST_SP_PWR: begin
					k_q <= k_q + 3'd1;
					if (k_q == 3'd7)
						s_q <= s_q + 1'b1;
				end
				ST_OUT_CAP: j_q <= j_q + 2'd1;
				ST_OUT_SND: if (cmd.next_grp) g_q <= g_q + 1'b1;
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept_rnd) begin
			line_q     <= in_line;
			sy_q       <= in_line + scy_q;
			wy_q       <= win_cnt_q;
			win_line_q <= win_line;
		end
		case (cmd.state)
			ST_PX_MAP: begin
				col_q <= win_px ? wc[2:0] : sx[2:0];
				row_q <= win_px ? wy_q[2:0] : sy_q[2:0];
				tok_q <= 1'b0;
			end
			ST_PX_LO: begin
				tok_q  <= (10'(bg_idx) < 10'(TILE_COUNT));
				addr_q <= tile_addr;
			end
			ST_PX_HI:   lo_q <= vram_rd_q;
			ST_SP_A1:   oy_q <= oam_rd_q;
			ST_SP_A2:   ox_q <= oam_rd_q;
			ST_SP_A3:   ot_q <= oam_rd_q;
			ST_SP_CHK: begin
				attr_q <= attr;
				addr_q <= spr_addr;
			end
			ST_SP_HI:   lo_q <= vram_rd_q;
			ST_SP_LOAD: hi_q <= vram_rd_q;
			ST_SP_PRD: begin
				p_q   <= pv[PIX_W-1:0];
				pin_q <= pin;
			end
			ST_OUT_CAP: word_q[8*j_q +: 8] <= grey;
			default: ;
		endcase
	end

	assign stat.disp_on  = lcdc_q[LC_DISP];
	assign stat.spr_on   = lcdc_q[LC_SPR];
	assign stat.fetch    = win_px || lcdc_q[LC_BG];
	assign stat.pix_last = (pix_q == PIX_W'(SCREEN_WIDTH - 1));
	assign stat.hit      = hit;
	assign stat.spr_last = (s_q == SC_W'(SPRITE_COUNT - 1));
	assign stat.k_last   = (k_q == 3'd7);
	assign stat.j_last   = (j_q == 2'd3);
	assign stat.grp_last = out_last;

	assign out_valid  = (cmd.state == ST_OUT_SND);
	assign out_group  = 6'(g_q);
	assign out_pixels = word_q;
	assign out_last   = (g_q == GR_W'(GROUPS - 1));

	a_win_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.accept |=> $stable(win_cnt_q))
		else $error("window counter moved without a request");

	a_group_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> j_q == 2'd0)
		else $error("group shown before all four pixels captured");

	a_pix_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.state == ST_PX_WR |-> 9'(pix_q) < 9'(SCREEN_WIDTH))
		else $error("line buffer write past line end");

endmodule
`default_nettype wire

>>> hw/rtl/tile_sprite_scanline_renderer_top.sv
// ---------------------------------------------------------------------------
// tile_sprite_scanline_renderer_top
// tile/sprite line renderer: video memory and sprite table writes, 4-pixel groups out
// ---------------------------------------------------------------------------
// channel   dir  handshake          contents
// s_*       in   tvalid/tready      write video byte, write sprite byte, render, window reset
// m_*       out  tvalid/tready      one group of four grey pixels, tlast on final group
// cfg_*     in   cfg_we only        eight 8-bit registers, no read-back
//
// write and window-reset requests are done when taken; the sequencer stays idle
// render, display on: per pixel a map read, low and high reads on one video memory port
//   and a line buffer write (map and write only with no fetch: background off, outside
//   the window); per sprite four table reads and a row check, plus for a sprite on the
//   line a high read, a load and a read/write per pixel; each group out reads four pixels
// render, display off: group output only
// one request at a time; a stalled m_tready holds the group and the sequencer
// reset returns control state, counters and config registers to defaults; memories hold no reset value
// ---------------------------------------------------------------------------
`default_nettype none
module tile_sprite_scanline_renderer_top #(
	parameter int SCREEN_WIDTH = 160,
	parameter int SPRITE_COUNT = 40,
	parameter int TILE_COUNT   = 384
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// request side
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,  // mem_address[12:0], mem_data[20:13], line_number[28:21]
	input  wire logic [1:0]  s_tuser,  // action[1:0]
	// result side
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [39:0]      m_tdata,  // group_index[5:0], grey_pixels[37:6]
	output logic             m_tlast,  // last_group
	// configuration
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [7:0]  cfg_data
);
	import tssr_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	// request fields
	logic [1:0]  action;
	logic [12:0] mem_address;
	logic [7:0]  mem_data;
	logic [7:0]  line_number;

	assign action      = s_tuser;
	assign mem_address = s_tdata[12:0];
	assign mem_data    = s_tdata[20:13];
	assign line_number = s_tdata[28:21];

	// result fields
	logic [5:0]  group_index;
	logic [31:0] grey_pixels;
	logic        last_group;

	// sequencer: accepts in idle, walks pixels, sprites and groups
	tssr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_action (action),
		.out_ready (m_tready),
		.stat      (stat),
		.cmd       (cmd),
		.in_ready  (s_tready)
	);

	// memories, registers and pixel arithmetic
	tssr_dp #(
		.SCREEN_WIDTH (SCREEN_WIDTH),
		.SPRITE_COUNT (SPRITE_COUNT),
		.TILE_COUNT   (TILE_COUNT)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_action  (action),
		.in_addr    (mem_address),
		.in_data    (mem_data),
		.in_line    (line_number),
		.cmd        (cmd),
		.stat       (stat),
		.out_valid  (m_tvalid),
		.out_group  (group_index),
		.out_pixels (grey_pixels),
		.out_last   (last_group)
	);

	// pack the result, pad to whole bytes
	assign m_tdata = {2'b00, grey_pixels, group_index};
	assign m_tlast = last_group;

endmodule
`default_nettype wire
